// ===== hw/rtl/wce_pkg.sv =====
// shared types and constants of the weak composition enumerator
package wce_pkg;

  localparam int SumDepth = 8;
  localparam int GapW     = 3;
  localparam int TotalW   = 8;
  localparam int PartW    = 8;
  localparam int PosW     = 4;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 8;

  localparam logic [CfgIdxW-1:0] CFG_OUTER_GAPS   = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_OUTER_TOTAL  = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_INNER_GAPS   = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_INNER_TOTAL  = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_PRODUCT_MODE = 3'd4;

  typedef struct packed {
    logic clear;
    logic advance;
  } wce_ctrl_t;

endpackage

// ===== hw/rtl/wce_cell.sv =====
// one partial sum cell of the enumerator chain
module wce_cell
  import wce_pkg::*;
#(
  parameter int VALUE_BITS = 8
) (
  input  logic                  clk_i,
  input  wce_ctrl_t             ctrl_i,
  input  logic                  active_i,
  input  logic [VALUE_BITS-1:0] total_i,
  input  logic [VALUE_BITS-1:0] left_psum_i,
  input  logic [VALUE_BITS-1:0] right_psum_i,
  input  logic                  claim_i,
  input  logic                  fill_vld_i,
  input  logic [VALUE_BITS-1:0] fill_val_i,
  output logic [VALUE_BITS-1:0] psum_o,
  output logic [VALUE_BITS-1:0] part_o,
  output logic                  claim_o,
  output logic                  fill_vld_o,
  output logic [VALUE_BITS-1:0] fill_val_o
);

  logic [VALUE_BITS-1:0] sum_q, sum_d;
  logic [VALUE_BITS-1:0] bumped;
  logic                  bump;

  assign psum_o     = active_i ? sum_q : total_i;
  assign part_o     = psum_o - left_psum_i;
  assign bumped     = sum_q + VALUE_BITS'(1);
  assign bump       = active_i && !claim_i && (sum_q != right_psum_i);
  assign claim_o    = active_i && (claim_i || bump);
  assign fill_vld_o = fill_vld_i || bump;
  assign fill_val_o = bump ? bumped : fill_val_i;

  always_comb begin
    sum_d = sum_q;
    if (ctrl_i.clear) begin
      sum_d = '0;
    end else if (ctrl_i.advance) begin
      if (bump) begin
        sum_d = bumped;
      end else if (active_i && fill_vld_i) begin
        sum_d = fill_val_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q <= sum_d;
  end

endmodule

// ===== hw/rtl/wce_chain.sv =====
// row of partial sum cells forming one enumerator
module wce_chain
  import wce_pkg::*;
#(
  parameter int VALUE_BITS = 8,
  parameter int PARTS      = 8
) (
  input  logic                  clk_i,
  input  logic                  clear_i,
  input  logic                  advance_i,
  input  logic [GapW-1:0]       gaps_i,
  input  logic [VALUE_BITS-1:0] total_i,
  input  logic [GapW-1:0]       sel_i,
  output logic [VALUE_BITS-1:0] part_o,
  output logic                  final_o,
  output logic                  wrap_o
);

  logic [VALUE_BITS-1:0] psum  [PARTS];
  logic [VALUE_BITS-1:0] parts [PARTS];
  logic                  claim [PARTS+1];
  logic                  fvld  [PARTS+1];
  logic [VALUE_BITS-1:0] fval  [PARTS+1];
  wce_ctrl_t             ctrl;

  assign claim[PARTS] = 1'b0;
  assign fvld[0]      = 1'b0;
  assign fval[0]      = '0;
  assign wrap_o       = !claim[0];
  assign final_o      = psum[0] == total_i;
  assign ctrl.clear   = clear_i || (advance_i && wrap_o);
  assign ctrl.advance = advance_i && !wrap_o;

  for (genvar j = 0; j < PARTS; j++) begin : g_cell
    logic [VALUE_BITS-1:0] left_psum;
    logic [VALUE_BITS-1:0] right_psum;

    if (j == 0) begin : g_first
      assign left_psum = '0;
    end else begin : g_mid
      assign left_psum = psum[j-1];
    end

    if (j == PARTS - 1) begin : g_last
      assign right_psum = total_i;
    end else begin : g_inner
      assign right_psum = psum[j+1];
    end

    wce_cell #(
      .VALUE_BITS(VALUE_BITS)
    ) u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .active_i    (GapW'(j) < gaps_i),
      .total_i     (total_i),
      .left_psum_i (left_psum),
      .right_psum_i(right_psum),
      .claim_i     (claim[j+1]),
      .fill_vld_i  (fvld[j]),
      .fill_val_i  (fval[j]),
      .psum_o      (psum[j]),
      .part_o      (parts[j]),
      .claim_o     (claim[j]),
      .fill_vld_o  (fvld[j+1]),
      .fill_val_o  (fval[j+1])
    );
  end

  always_comb begin
    part_o = '0;
    for (int j = 0; j < PARTS; j++) begin
      if (sel_i == GapW'(j)) begin
        part_o = parts[j];
      end
    end
  end

endmodule

// ===== hw/rtl/weak_composition_enumerator_core.sv =====
// Weak composition enumerator: each request transaction emits the current vector of
// non-negative parts, one part per output transaction, in lexicographic order, then
// steps to the next vector (wrapping after the last). Product mode emits an outer and
// an inner vector back to back, the inner one stepping fastest. A request is taken and then
// emits outer_gaps+1 parts, plus inner_gaps+1 in product mode, so 1 to 16 parts; the single
// output register issues one part per cycle while the output is not stalled, and the next
// request is taken the cycle after the last part is loaded. Each enumerator is a row of cells,
// one partial sum per cell; it steps in the same cycle as the last part of the vector is issued,
// the outer one in product mode only when the inner one wraps.
module weak_composition_enumerator_core
  import wce_pkg::*;
#(
  parameter int MAX_PARTS  = 8,
  parameter int VALUE_BITS = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                restart_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [PartW-1:0]    part_value_o,
  output logic [PosW-1:0]     part_position_o,
  output logic                vector_end_o,
  output logic                sequence_end_o
);

  localparam int Parts  = (MAX_PARTS < SumDepth) ? MAX_PARTS : SumDepth;
  localparam int GapLim = Parts - 1;
  localparam int TW     = (VALUE_BITS > TotalW) ? VALUE_BITS : TotalW;
  localparam int VMax   = (1 << VALUE_BITS) - 1;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EMIT = 1'b1;

  logic [GapW-1:0]   outer_gaps_q, inner_gaps_q;
  logic [TotalW-1:0] outer_total_q, inner_total_q;
  logic              product_mode_q;
  logic              fresh_q;
  logic              state_q;
  logic              phase_q;
  logic [GapW-1:0]   idx_q;
  logic [PosW-1:0]   pos_q;
  logic              out_valid_q;
  logic [PartW-1:0]  part_value_q;
  logic [PosW-1:0]   part_position_q;
  logic              vector_end_q;
  logic              sequence_end_q;

  logic [GapW-1:0]       og, ig, cur_gaps;
  logic [TW-1:0]         ot_w, it_w;
  logic [VALUE_BITS-1:0] ot, it;
  logic [VALUE_BITS-1:0] outer_part, inner_part;
  logic [TW-1:0]         part_w;
  logic                  outer_final, inner_final, outer_wrap, inner_wrap;
  logic                  accept, load, emit, last_in_phase, vend, seq;
  logic                  outer_adv, inner_adv;

  assign og   = (outer_gaps_q > GapW'(GapLim)) ? GapW'(GapLim) : outer_gaps_q;
  assign ig   = (inner_gaps_q > GapW'(GapLim)) ? GapW'(GapLim) : inner_gaps_q;
  assign ot_w = (TW'(outer_total_q) > TW'(VMax)) ? TW'(VMax) : TW'(outer_total_q);
  assign it_w = (TW'(inner_total_q) > TW'(VMax)) ? TW'(VMax) : TW'(inner_total_q);
  assign ot   = ot_w[VALUE_BITS-1:0];
  assign it   = it_w[VALUE_BITS-1:0];

  assign accept        = in_valid_i && (state_q == ST_IDLE);
  assign load          = accept && (restart_i || fresh_q);
  assign emit          = (state_q == ST_EMIT) && (!out_valid_q || !out_stall_i);
  assign cur_gaps      = phase_q ? ig : og;
  assign last_in_phase = idx_q == cur_gaps;
  assign vend          = last_in_phase && (phase_q || !product_mode_q);
  assign seq           = vend && outer_final && (!product_mode_q || inner_final);
  assign part_w        = phase_q ? TW'(inner_part) : TW'(outer_part);
  assign inner_adv     = emit && vend && product_mode_q;
  assign outer_adv     = emit && vend && (!product_mode_q || inner_wrap);

  wce_chain #(
    .VALUE_BITS(VALUE_BITS),
    .PARTS     (Parts)
  ) u_outer (
    .clk_i    (clk_i),
    .clear_i  (load),
    .advance_i(outer_adv),
    .gaps_i   (og),
    .total_i  (ot),
    .sel_i    (idx_q),
    .part_o   (outer_part),
    .final_o  (outer_final),
    .wrap_o   (outer_wrap)
  );

  wce_chain #(
    .VALUE_BITS(VALUE_BITS),
    .PARTS     (Parts)
  ) u_inner (
    .clk_i    (clk_i),
    .clear_i  (load),
    .advance_i(inner_adv),
    .gaps_i   (ig),
    .total_i  (it),
    .sel_i    (idx_q),
    .part_o   (inner_part),
    .final_o  (inner_final),
    .wrap_o   (inner_wrap)
  );

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      outer_gaps_q   <= '0;
      outer_total_q  <= '0;
      inner_gaps_q   <= '0;
      inner_total_q  <= '0;
      product_mode_q <= 1'b0;
      fresh_q        <= 1'b1;
    end else begin
      if (accept) begin
        fresh_q <= 1'b0;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_OUTER_GAPS: begin
            outer_gaps_q <= cfg_wdata_i[GapW-1:0];
            fresh_q      <= 1'b1;
          end
          CFG_OUTER_TOTAL: begin
            outer_total_q <= cfg_wdata_i[TotalW-1:0];
            fresh_q       <= 1'b1;
          end
          CFG_INNER_GAPS: begin
            inner_gaps_q <= cfg_wdata_i[GapW-1:0];
            fresh_q      <= 1'b1;
          end
          CFG_INNER_TOTAL: begin
            inner_total_q <= cfg_wdata_i[TotalW-1:0];
            fresh_q       <= 1'b1;
          end
          CFG_PRODUCT_MODE: begin
            product_mode_q <= cfg_wdata_i[0];
            fresh_q        <= 1'b1;
          end
          default: begin
          end
        endcase
      end
    end
  end

  // emission sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= 1'b0;
      idx_q       <= '0;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        state_q <= ST_EMIT;
        phase_q <= 1'b0;
        idx_q   <= '0;
        pos_q   <= '0;
      end else if (emit) begin
        pos_q <= pos_q + PosW'(1);
        if (vend) begin
          state_q <= ST_IDLE;
        end else if (last_in_phase) begin
          phase_q <= 1'b1;
          idx_q   <= '0;
        end else begin
          idx_q <= idx_q + GapW'(1);
        end
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      part_value_q    <= part_w[PartW-1:0];
      part_position_q <= pos_q;
      vector_end_q    <= vend;
      sequence_end_q  <= seq;
    end
  end

  assign in_stall_o      = state_q != ST_IDLE;
  assign out_valid_o     = out_valid_q;
  assign part_value_o    = part_value_q;
  assign part_position_o = part_position_q;
  assign vector_end_o    = vector_end_q;
  assign sequence_end_o  = sequence_end_q;

  a_idle_after_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit && vend |=> state_q == ST_IDLE)
    else $error("sequencer still busy after last part");

  a_seq_end_on_vec_end : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (!sequence_end_o || vector_end_o))
    else $error("sequence end outside vector end");

  a_start_at_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == ST_EMIT) && (pos_q == '0) && !phase_q)
    else $error("emission does not start at position zero");

endmodule

// ===== tb/tb_weak_composition_enumerator_core.sv =====
`timescale 1ns / 1ps
// self-checking testbench of the weak composition enumerator core with its own enumeration model
module tb_weak_composition_enumerator_core;
  import wce_pkg::*;

  localparam int CycleLimit     = 500000;
  localparam int SettleCycles   = 20;
  localparam int RandomRequests = 380;
  localparam int FirstSpareIdx  = CFG_PRODUCT_MODE + 1;
  localparam int LastSpareIdx   = 2 ** CfgIdxW - 1;

  typedef logic [SumDepth-1:0][PartW-1:0] sums_t;

  typedef struct packed {
    logic [PartW-1:0] value;
    logic [PosW-1:0]  position;
    logic             vector_end;
    logic             sequence_end;
  } part_t;

  typedef struct packed {
    logic [CfgIdxW-1:0]  idx;
    logic [CfgDataW-1:0] data;
  } reg_write_t;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i   = '0;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  logic                restart_i   = 1'b0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [PartW-1:0]    part_value_o;
  logic [PosW-1:0]     part_position_o;
  logic                vector_end_o;
  logic                sequence_end_o;

  weak_composition_enumerator_core DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .restart_i      (restart_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .part_value_o   (part_value_o),
    .part_position_o(part_position_o),
    .vector_end_o   (vector_end_o),
    .sequence_end_o (sequence_end_o)
  );

  // enumeration model state
  logic [GapW-1:0]   outer_gaps, inner_gaps;
  logic [TotalW-1:0] outer_total, inner_total;
  logic              product_on;
  sums_t             outer_sums, inner_sums;
  logic              fresh;

  part_t      expected_parts[$];
  reg_write_t reg_writes[$];
  part_t      want;

  int send_idle_pct  = 29;
  int recv_stall_pct = 64;
  int errors         = 0;
  int cycles         = 0;
  int requests_sent  = 0;
  int parts_checked  = 0;
  int vectors_seen   = 0;
  int finals_seen    = 0;
  int writes_done    = 0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("[weak_composition_enumerator_core] ERROR");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  function automatic logic [PartW-1:0] partial_sum(sums_t s, int gaps, int total, int j);
    if (j >= gaps) return PartW'(total);
    return s[j];
  endfunction

  function automatic logic is_last_vector(sums_t s, int gaps, int total);
    return gaps == 0 || s[0] == PartW'(total);
  endfunction

  // returns one when the enumeration wrapped to its first vector
  function automatic logic step_sums(inout sums_t s, input int gaps, input int total);
    int i;
    for (int j = gaps; j > 0; j--) begin
      i = j - 1;
      if (s[i] != partial_sum(s, gaps, total, i + 1)) begin
        s[i] = s[i] + 1'b1;
        for (int k = i + 1; k < gaps; k++) s[k] = s[i];
        return 1'b0;
      end
    end
    s = '0;
    return 1'b1;
  endfunction

  function automatic int queue_vector(sums_t s, int gaps, int total, int base,
                                      logic last_block, logic seq_end);
    part_t            p;
    logic [PartW-1:0] lo;
    for (int j = 0; j <= gaps; j++) begin
      lo = (j == 0) ? '0 : partial_sum(s, gaps, total, j - 1);
      p.value        = partial_sum(s, gaps, total, j) - lo;
      p.position     = PosW'(base + j);
      p.vector_end   = last_block && (j == gaps);
      p.sequence_end = p.vector_end && seq_end;
      expected_parts.push_back(p);
    end
    return gaps + 1;
  endfunction

  function automatic void compute_parts(logic restart);
    logic seq;
    int   n;
    if (restart || fresh) begin
      outer_sums = '0;
      inner_sums = '0;
      fresh      = 1'b0;
    end
    if (product_on) begin
      seq = is_last_vector(outer_sums, outer_gaps, outer_total) &&
            is_last_vector(inner_sums, inner_gaps, inner_total);
      n = queue_vector(outer_sums, outer_gaps, outer_total, 0, 1'b0, 1'b0);
      void'(queue_vector(inner_sums, inner_gaps, inner_total, n, 1'b1, seq));
      if (step_sums(inner_sums, inner_gaps, inner_total))
        void'(step_sums(outer_sums, outer_gaps, outer_total));
    end else begin
      seq = is_last_vector(outer_sums, outer_gaps, outer_total);
      void'(queue_vector(outer_sums, outer_gaps, outer_total, 0, 1'b1, seq));
      void'(step_sums(outer_sums, outer_gaps, outer_total));
    end
  endfunction

  function automatic void apply_reg_write(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    logic known;
    known = 1'b1;
    case (idx)
      CFG_OUTER_GAPS:   outer_gaps  = data[GapW-1:0];
      CFG_OUTER_TOTAL:  outer_total = data[TotalW-1:0];
      CFG_INNER_GAPS:   inner_gaps  = data[GapW-1:0];
      CFG_INNER_TOTAL:  inner_total = data[TotalW-1:0];
      CFG_PRODUCT_MODE: product_on  = data[0];
      default:          known = 1'b0;
    endcase
    if (known) fresh = 1'b1;
  endfunction

  task automatic check_field(input string name, input int exp_val, input int act_val);
    if (exp_val != act_val) begin
      errors++;
      if (errors < 60)
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_val, act_val);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_parts.size() == 0) begin
        errors++;
        if (errors < 60)
          $display("%0t: unexpected part, expected none, actual value %0d position %0d",
                   $time, part_value_o, part_position_o);
      end else begin
        want = expected_parts.pop_front();
        check_field("part_value", want.value, part_value_o);
        check_field("part_position", want.position, part_position_o);
        check_field("vector_end", want.vector_end, vector_end_o);
        check_field("sequence_end", want.sequence_end, sequence_end_o);
        parts_checked++;
        if (vector_end_o) vectors_seen++;
        if (sequence_end_o) finals_seen++;
      end
    end
  end

  task automatic send_request(input logic restart);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      restart_i  <= 1'($urandom_range(1));
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    restart_i  <= restart;
    do @(posedge clk_i); while (in_stall_o);
    compute_parts(restart);
    requests_sent++;
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (expected_parts.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic flush_writes();
    reg_write_t w;
    while (reg_writes.size() != 0) begin
      w = reg_writes.pop_front();
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= w.idx;
      cfg_wdata_i <= w.data;
      apply_reg_write(w.idx, w.data);
      writes_done++;
      @(negedge clk_i);
    end
    cfg_we_i <= 1'b0;
  endtask

  task automatic configure(input int og, input int ot, input int ig, input int it, input int pm);
    wait_idle();
    reg_writes.push_back(reg_write_t'({CFG_OUTER_GAPS, CfgDataW'(og)}));
    reg_writes.push_back(reg_write_t'({CFG_OUTER_TOTAL, CfgDataW'(ot)}));
    reg_writes.push_back(reg_write_t'({CFG_INNER_GAPS, CfgDataW'(ig)}));
    reg_writes.push_back(reg_write_t'({CFG_INNER_TOTAL, CfgDataW'(it)}));
    reg_writes.push_back(reg_write_t'({CFG_PRODUCT_MODE, CfgDataW'(pm)}));
    flush_writes();
  endtask

  // registers at their reset values: one part of value zero
  task automatic test_reset_state();
    send_request(1'b0);
    send_request(1'b0);
  endtask

  task automatic test_single_part();
    configure(0, 255, 0, 0, 0);
    send_request(1'b0);
    send_request(1'b1);
  endtask

  // three vectors, restart in the middle, then a wrap
  task automatic test_small_walk();
    configure(1, 2, 0, 0, 0);
    send_request(1'b0);
    send_request(1'b0);
    send_request(1'b1);
    send_request(1'b0);
    send_request(1'b0);
    send_request(1'b0);
  endtask

  task automatic test_product_wrap();
    configure(1, 1, 1, 1, 1);
    repeat (5) send_request(1'b0);
  endtask

  task automatic test_widest_pair();
    configure(7, 255, 7, 255, 1);
    send_request(1'b0);
    send_request(1'b0);
  endtask

  // spare indexes keep the walk going, a real write starts it over
  task automatic test_write_effects();
    configure(2, 4, 0, 0, 0);
    send_request(1'b0);
    send_request(1'b0);
    wait_idle();
    for (int idx = FirstSpareIdx; idx <= LastSpareIdx; idx++)
      reg_writes.push_back(reg_write_t'({CfgIdxW'(idx), CfgDataW'($urandom_range(255))}));
    reg_writes.push_back(reg_write_t'({CfgIdxW'(LastSpareIdx), {CfgDataW{1'b1}}}));
    flush_writes();
    send_request(1'b0);
    send_request(1'b0);
    wait_idle();
    reg_writes.push_back(reg_write_t'({CFG_OUTER_TOTAL, CfgDataW'(4)}));
    flush_writes();
    send_request(1'b0);
    send_request(1'b0);
  endtask

  task automatic test_random_walks();
    int done;
    int burst;
    int val;
    done = 0;
    while (done < RandomRequests) begin
      if (done < RandomRequests / 3) begin
        send_idle_pct  = 29;
        recv_stall_pct = 64;
      end else if (done < 2 * RandomRequests / 3) begin
        send_idle_pct  = 64;
        recv_stall_pct = 29;
      end else begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      wait_idle();
      for (int r = CFG_OUTER_GAPS; r <= CFG_PRODUCT_MODE; r++) begin
        if ($urandom_range(99) < 75) begin
          case (CfgIdxW'(r))
            CFG_OUTER_GAPS, CFG_INNER_GAPS:
              val = ($urandom_range(9) < 8) ? $urandom_range(2) : $urandom_range(7);
            CFG_OUTER_TOTAL, CFG_INNER_TOTAL:
              case ($urandom_range(19))
                0:       val = 255;
                1, 2:    val = $urandom_range(255);
                default: val = $urandom_range(5);
              endcase
            default:
              val = $urandom_range(1);
          endcase
          reg_writes.push_back(reg_write_t'({CfgIdxW'(r), CfgDataW'(val)}));
        end
      end
      if ($urandom_range(9) == 0)
        reg_writes.push_back(reg_write_t'({CfgIdxW'($urandom_range(LastSpareIdx, FirstSpareIdx)),
                                           CfgDataW'($urandom_range(255))}));
      flush_writes();
      burst = $urandom_range(30, 8);
      for (int b = 0; b < burst; b++) begin
        send_request($urandom_range(99) < 8);
        done++;
      end
    end
  endtask

  initial begin
    outer_gaps  = '0;
    outer_total = '0;
    inner_gaps  = '0;
    inner_total = '0;
    product_on  = 1'b0;
    outer_sums  = '0;
    inner_sums  = '0;
    fresh       = 1'b1;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_reset_state();
    test_single_part();
    test_small_walk();
    test_product_wrap();
    test_widest_pair();
    test_write_effects();
    test_random_walks();
    wait_idle();

    $display("covered %0d requests and %0d register writes, %0d parts checked",
             requests_sent, writes_done, parts_checked);
    $display("saw %0d vectors, %0d of them closing an enumeration", vectors_seen, finals_seen);
    if (errors == 0) begin
      $display("[weak_composition_enumerator_core] OK");
    end else begin
      $display("[weak_composition_enumerator_core] ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/wce_pkg.sv
hw/rtl/wce_cell.sv
hw/rtl/wce_chain.sv
hw/rtl/weak_composition_enumerator_core.sv
tb/tb_weak_composition_enumerator_core.sv
